@@ hdl/hts_pkg.sv @@
// Shared types, constants and helpers of the heightfield triangle sampler.
// Used by hts_bank and heightfield_triangle_sample; depends on nothing else.
package hts_pkg;

   localparam int HEIGHT_W             = 16;
   localparam int FRAC_W               = 8;
   localparam int POINTS_W             = 7;
   localparam int CELL_W               = 6;
   localparam int CSR_ADDR_W           = 1;
   localparam int MAX_POINTS_X_DEFAULT = 64;
   localparam int MAX_POINTS_Z_DEFAULT = 64;

   localparam logic [POINTS_W-1:0]   POINTS_RESET      = 7'd20;
   localparam logic [POINTS_W-1:0]   POINTS_MIN        = 7'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_POINTS_ACROSS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_POINTS_DEEP   = 1'b1;
   localparam logic                  ACTION_WRITE      = 1'b0;
   localparam logic                  ACTION_QUERY      = 1'b1;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic [FRAC_W-1:0]          frac_type;
   typedef logic [POINTS_W-1:0]        points_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_col;
      logic [CELL_W-1:0] cell_row;
      logic              upper;
   } cell_type;

   function automatic points_type clamp_points(input points_type value, input int hi);
      points_type result;
      if (value < POINTS_MIN) begin
         result = POINTS_MIN;
      end else if (int'(value) > hi) begin
         result = POINTS_W'(hi);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

@@ hdl/heightfield_triangle_sample.sv @@
// Top level of the heightfield triangle sampler: grid load, clamp, banked read,
// triangle select, multiply and saturating sum. Depends on hts_pkg and hts_bank.
//
//  channel | ports     | direction | carries
//  req     | req_t*    | in        | grid write or height query item
//  rsp     | rsp_t*    | out       | interpolated height item, one per query
//  csr     | csr_*     | in        | points_across, points_deep
//
// One item per cycle unless rsp stalls; a query is registered through clamp,
// bank read, select, multiply, sum and saturate before it is valid on rsp.
// Writes land in one of the four parity banks at accept and give no item.
// Reset clears valid bits and sets both point counts to 20; the grid holds
// garbage until written. A stall on rsp fills bubbles, then holds every stage.
module heightfield_triangle_sample #(
   parameter int MAX_POINTS_X = hts_pkg::MAX_POINTS_X_DEFAULT,
   parameter int MAX_POINTS_Z = hts_pkg::MAX_POINTS_Z_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // point_col[5:0], point_row[11:6], point_height[27:12], x_pos[45:28], z_pos[63:46]
   input  logic [63:0]                    req_tdata,
   // action[0]
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // height[15:0], cell_col[21:16], cell_row[27:22], upper_triangle[28], zero[31:29]
   output logic [31:0]                    rsp_tdata,
   input  logic                           csr_we,
   input  logic [hts_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hts_pkg::POINTS_W-1:0]   csr_wdata
);

   localparam int COL_W  = $clog2(MAX_POINTS_X);
   localparam int ROW_W  = $clog2(MAX_POINTS_Z);
   localparam int HC_RAW = $clog2((MAX_POINTS_X + 1) / 2);
   localparam int HR_RAW = $clog2((MAX_POINTS_Z + 1) / 2);
   localparam int HC_W   = (HC_RAW < 1) ? 1 : HC_RAW;
   localparam int HR_W   = (HR_RAW < 1) ? 1 : HR_RAW;
   localparam int ADDR_W = HC_W + HR_W;
   localparam int POS_W  = hts_pkg::POINTS_W + hts_pkg::FRAC_W;
   localparam int DIFF_W = hts_pkg::HEIGHT_W + 1;
   localparam int PROD_W = DIFF_W + hts_pkg::FRAC_W + 1;
   localparam int TERM_W = PROD_W - hts_pkg::FRAC_W;
   localparam int SUM_W  = TERM_W + 2;

   // configuration
   hts_pkg::points_type points_across_ff, points_across_in;
   hts_pkg::points_type points_deep_ff, points_deep_in;

   always_comb begin
      points_across_in = points_across_ff;
      points_deep_in   = points_deep_ff;
      if (csr_we) begin
         unique case (csr_addr)
            hts_pkg::CSR_POINTS_ACROSS:
               points_across_in = hts_pkg::clamp_points(csr_wdata, MAX_POINTS_X);
            hts_pkg::CSR_POINTS_DEEP:
               points_deep_in = hts_pkg::clamp_points(csr_wdata, MAX_POINTS_Z);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_across_ff <= hts_pkg::POINTS_RESET;
         points_deep_ff   <= hts_pkg::POINTS_RESET;
      end else begin
         points_across_ff <= points_across_in;
         points_deep_ff   <= points_deep_in;
      end
   end

   // handshake and stage valids
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
   logic req_fire, query_fire, write_fire;

   assign s5_ready   = !s5_v_ff || rsp_tready;
   assign s4_ready   = !s4_v_ff || s5_ready;
   assign s3_ready   = !s3_v_ff || s4_ready;
   assign s2_ready   = !s2_v_ff || s3_ready;
   assign s1_ready   = !s1_v_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign query_fire = req_fire && (req_tuser[0] == hts_pkg::ACTION_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_v_ff <= query_fire;
         if (s2_ready) s2_v_ff <= s1_v_ff;
         if (s3_ready) s3_v_ff <= s2_v_ff;
         if (s4_ready) s4_v_ff <= s3_v_ff;
         if (s5_ready) s5_v_ff <= s4_v_ff;
      end
   end

   // input fields
   logic [5:0]                 in_col, in_row;
   hts_pkg::height_type        in_height;
   logic signed [17:0]         in_x, in_z;

   assign in_col    = req_tdata[5:0];
   assign in_row    = req_tdata[11:6];
   assign in_height = $signed(req_tdata[27:12]);
   assign in_x      = $signed(req_tdata[45:28]);
   assign in_z      = $signed(req_tdata[63:46]);

   // write path into the parity banks
   logic              wr_in_range;
   logic [ADDR_W-1:0] wr_addr;

   assign wr_in_range = (int'(in_col) < MAX_POINTS_X) && (int'(in_row) < MAX_POINTS_Z);
   assign write_fire  = req_fire && (req_tuser[0] == hts_pkg::ACTION_WRITE) && wr_in_range;
   assign wr_addr     = {HC_W'(in_col[5:1]), HR_W'(in_row[5:1])};

   // stage 1: clamp and split
   logic [POS_W-1:0]       xmax, dmax, xc, dc;
   logic signed [18:0]     dv;
   hts_pkg::points_type    col_full, row_full;
   logic [COL_W-1:0]       s1_col_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   hts_pkg::frac_type      s1_fx_ff, s1_fz_ff;
   logic                   s1_last_col_ff, s1_last_row_ff;
   hts_pkg::cell_type      s1_cell_ff, s1_cell_in;

   always_comb begin
      xmax = {points_across_ff - 7'd1, 8'd0};
      dmax = {points_deep_ff - 7'd1, 8'd0};
      dv   = -{in_z[17], in_z};
      if (in_x[17]) begin
         xc = '0;
      end else if (in_x[16:0] > {2'b00, xmax}) begin
         xc = xmax;
      end else begin
         xc = in_x[POS_W-1:0];
      end
      if (dv[18]) begin
         dc = '0;
      end else if (dv[17:0] > {3'b000, dmax}) begin
         dc = dmax;
      end else begin
         dc = dv[POS_W-1:0];
      end
      col_full            = xc[POS_W-1:hts_pkg::FRAC_W];
      row_full            = dc[POS_W-1:hts_pkg::FRAC_W];
      s1_cell_in.cell_col = col_full[5:0];
      s1_cell_in.cell_row = row_full[5:0];
      s1_cell_in.upper    = dc[7:0] > xc[7:0];
   end

   always_ff @(posedge clock) begin
      if (query_fire) begin
         s1_col_ff      <= COL_W'(col_full);
         s1_row_ff      <= ROW_W'(row_full);
         s1_fx_ff       <= xc[7:0];
         s1_fz_ff       <= dc[7:0];
         s1_last_col_ff <= col_full == points_across_ff - 7'd1;
         s1_last_row_ff <= row_full == points_deep_ff - 7'd1;
         s1_cell_ff     <= s1_cell_in;
      end
   end

   // stage 2: banked read of the four corners
   logic [COL_W:0]                           col_next;
   logic [ROW_W:0]                           row_next;
   logic                                     rd_en;
   logic [3:0][hts_pkg::HEIGHT_W-1:0]        bank_q;

   assign col_next = {1'b0, s1_col_ff} + 1'b1;
   assign row_next = {1'b0, s1_row_ff} + 1'b1;
   assign rd_en    = s1_v_ff && s2_ready;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [COL_W:0]      cb;
      logic [ROW_W:0]      rb;
      logic [ADDR_W-1:0]   rd_addr;
      hts_pkg::height_type q;

      assign cb      = (s1_col_ff[0] == b[1]) ? {1'b0, s1_col_ff} : col_next;
      assign rb      = (s1_row_ff[0] == b[0]) ? {1'b0, s1_row_ff} : row_next;
      assign rd_addr = {HC_W'(cb >> 1), HR_W'(rb >> 1)};

      hts_bank #(
         .ADDR_W (ADDR_W)
      ) u_bank (
         .clock   (clock),
         .wr_en   (write_fire && (in_col[0] == b[1]) && (in_row[0] == b[0])),
         .wr_addr (wr_addr),
         .wr_data (in_height),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (q)
      );

      assign bank_q[b] = q;
   end

   logic              s2_c0_ff, s2_r0_ff;
   hts_pkg::frac_type s2_fx_ff, s2_fz_ff;
   logic              s2_last_col_ff, s2_last_row_ff;
   hts_pkg::cell_type s2_cell_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s2_c0_ff       <= s1_col_ff[0];
         s2_r0_ff       <= s1_row_ff[0];
         s2_fx_ff       <= s1_fx_ff;
         s2_fz_ff       <= s1_fz_ff;
         s2_last_col_ff <= s1_last_col_ff;
         s2_last_row_ff <= s1_last_row_ff;
         s2_cell_ff     <= s1_cell_ff;
      end
   end

   // stage 3: pick the triangle, form the edge differences
   hts_pkg::height_type       h00, h01, h10, h11, ha;
   logic signed [DIFF_W-1:0]  d1_in, d2_in;
   logic                      en1, en2;
   logic                      s3_load;
   hts_pkg::height_type       s3_h00_ff;
   logic signed [DIFF_W-1:0]  s3_d1_ff, s3_d2_ff;
   hts_pkg::frac_type         s3_f1_ff, s3_f2_ff;
   hts_pkg::cell_type         s3_cell_ff;

   always_comb begin
      h00   = $signed(bank_q[{s2_c0_ff, s2_r0_ff}]);
      h01   = $signed(bank_q[{s2_c0_ff, ~s2_r0_ff}]);
      h10   = $signed(bank_q[{~s2_c0_ff, s2_r0_ff}]);
      h11   = $signed(bank_q[{~s2_c0_ff, ~s2_r0_ff}]);
      ha    = s2_cell_ff.upper ? h01 : h10;
      en1   = s2_cell_ff.upper ? !s2_last_row_ff : !s2_last_col_ff;
      en2   = !s2_last_row_ff && !s2_last_col_ff;
      d1_in = en1 ? (DIFF_W'(ha) - DIFF_W'(h00)) : '0;
      d2_in = en2 ? (DIFF_W'(h11) - DIFF_W'(ha)) : '0;
   end

   assign s3_load = s2_v_ff && s3_ready;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_h00_ff  <= h00;
         s3_d1_ff   <= d1_in;
         s3_d2_ff   <= d2_in;
         s3_f1_ff   <= s2_cell_ff.upper ? s2_fz_ff : s2_fx_ff;
         s3_f2_ff   <= s2_cell_ff.upper ? s2_fx_ff : s2_fz_ff;
         s3_cell_ff <= s2_cell_ff;
      end
   end

   // stage 4: two products
   logic signed [PROD_W-1:0] p1_in, p2_in, s4_p1_ff, s4_p2_ff;
   hts_pkg::height_type      s4_h00_ff;
   hts_pkg::cell_type        s4_cell_ff;

   assign p1_in = $signed({1'b0, s3_f1_ff}) * s3_d1_ff;
   assign p2_in = $signed({1'b0, s3_f2_ff}) * s3_d2_ff;

   always_ff @(posedge clock) begin
      if (s3_v_ff && s4_ready) begin
         s4_p1_ff   <= p1_in;
         s4_p2_ff   <= p2_in;
         s4_h00_ff  <= s3_h00_ff;
         s4_cell_ff <= s3_cell_ff;
      end
   end

   // stage 5: truncate toward zero, add, saturate
   logic signed [PROD_W-1:0] p1_adj, p2_adj;
   logic signed [TERM_W-1:0] t1, t2;
   logic signed [SUM_W-1:0]  sum;
   hts_pkg::height_type      height_in, s5_height_ff;
   hts_pkg::cell_type        s5_cell_ff;

   always_comb begin
      p1_adj = s4_p1_ff + (s4_p1_ff[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      p2_adj = s4_p2_ff + (s4_p2_ff[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      t1     = p1_adj[PROD_W-1:hts_pkg::FRAC_W];
      t2     = p2_adj[PROD_W-1:hts_pkg::FRAC_W];
      sum    = SUM_W'(s4_h00_ff) + SUM_W'(t1) + SUM_W'(t2);
      if (sum > SUM_W'(32767)) begin
         height_in = 16'sh7FFF;
      end else if (sum < -SUM_W'(32768)) begin
         height_in = 16'sh8000;
      end else begin
         height_in = sum[hts_pkg::HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_v_ff && s5_ready) begin
         s5_height_ff <= height_in;
         s5_cell_ff   <= s4_cell_ff;
      end
   end

   assign rsp_tvalid = s5_v_ff;
   assign rsp_tdata  = {3'b000, s5_cell_ff.upper, s5_cell_ff.cell_row,
                        s5_cell_ff.cell_col, s5_height_ff};

   // checks
   a_points_in_range: assert property (@(posedge clock) disable iff (reset)
      (points_across_ff >= hts_pkg::POINTS_MIN) && (int'(points_across_ff) <= MAX_POINTS_X)
      && (points_deep_ff >= hts_pkg::POINTS_MIN) && (int'(points_deep_ff) <= MAX_POINTS_Z))
      else $error("point count outside its clamp range");

   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !s3_ready) |=> $stable(bank_q))
      else $error("bank read data changed under a stalled stage");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s4_v_ff))
      else $error("result item appeared without a query in the multiply stage");

endmodule

@@ hdl/hts_bank.sv @@
// One bank of the height grid: single write port, one registered read port.
// Depends on hts_pkg for the height type.
module hts_bank #(
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  hts_pkg::height_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output hts_pkg::height_type rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   hts_pkg::height_type mem [DEPTH];
   hts_pkg::height_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ bench/tb_heightfield_triangle_sample.sv @@
// Testbench for heightfield_triangle_sample: loads grid heights, queries positions
// and checks each result's height, cell and triangle flag against its own triangle
// predictor or a fixed expected value. Depends on hts_pkg and the RTL.
module tb_heightfield_triangle_sample;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_X      = hts_pkg::MAX_POINTS_X_DEFAULT;
   localparam int GRID_Z      = hts_pkg::MAX_POINTS_Z_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 7;
   localparam int ITEMS       = 1850;

   typedef struct packed {
      hts_pkg::height_type height;
      hts_pkg::cell_type   spot;
   } sample_type;

   typedef struct {
      logic act;
      int   col, row, hgt, x, z;
      bit   known;
      int   e_h, e_col, e_row;
      bit   e_up;
   } step_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [63:0]                    req_tdata  = '0;
   logic [0:0]                     req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [31:0]                    rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [hts_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [hts_pkg::POINTS_W-1:0]   csr_wdata  = '0;

   hts_pkg::height_type grid_h [GRID_X][GRID_Z];
   bit                  grid_set [GRID_X][GRID_Z];
   int                  across = 20;
   int                  deep   = 20;
   sample_type          pending_samples [$];
   sample_type          seen, due;
   int                  fail_count = 0;
   int                  quiet = 0;
   int                  sent_items = 0;
   bit                  gaps_on  = 1'b1;
   bit                  stall_on = 1'b1;

   step_type plan [19] = '{
      '{hts_pkg::ACTION_WRITE,  0,  0, 'h0100,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE,  1,  0, 'h0200,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE,  0,  1, 'h0300,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE,  1,  1, 'h0400,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,       0,       0, 1, 'h0100,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0, -131072,  131071, 1, 'h0100,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,   'h080,  -'h0C0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,   'h040,  -'h040, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,   'h0C0,  -'h010, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE, 19, 19,  32767,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,  131071, -131072, 1,  32767, 19, 19, 0},
      '{hts_pkg::ACTION_WRITE, 63, 63, -32768,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE, 19,  5, 'h1000,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE, 19,  6,  -4096,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,    4864,   -1344, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,  131071,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_WRITE,  0, 19, -32768,       0,       0, 0,      0,  0,  0, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,      -1, -131072, 1, -32768,  0, 19, 0},
      '{hts_pkg::ACTION_QUERY,  0,  0,      0,   'h1FF,  -'h1FF, 0,      0,  0,  0, 0}
   };

   int phase_across [PHASES] = '{0, 127, 2, 64, 7, 0, 20};
   int phase_deep   [PHASES] = '{127, 1, 2, 64, 13, 0, 20};

   heightfield_triangle_sample uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void locate(input int xq, input int zq,
                                  output int col, output int row,
                                  output int fx, output int fz);
      int x, d;
      x = xq;
      d = -zq;
      if (x < 0) begin
         x = 0;
      end
      if (x > (across - 1) * 256) begin
         x = (across - 1) * 256;
      end
      if (d < 0) begin
         d = 0;
      end
      if (d > (deep - 1) * 256) begin
         d = (deep - 1) * 256;
      end
      col = x >> 8;
      row = d >> 8;
      fx  = x & 255;
      fz  = d & 255;
   endfunction

   function automatic sample_type interpolate_height(input int xq, input int zq);
      sample_type s;
      int col, row, fx, fz, h00, h01, h10, h;
      locate(xq, zq, col, row, fx, fz);
      h00 = grid_h[col][row];
      h   = h00;
      s.spot.upper = fz > fx;
      if (s.spot.upper) begin
         if (row != deep - 1) begin
            h01 = grid_h[col][row + 1];
            h += (fz * (h01 - h00)) / 256;
            if (col != across - 1) begin
               h += (fx * (int'(grid_h[col + 1][row + 1]) - h01)) / 256;
            end
         end
      end else if (col != across - 1) begin
         h10 = grid_h[col + 1][row];
         h += (fx * (h10 - h00)) / 256;
         if (row != deep - 1) begin
            h += (fz * (int'(grid_h[col + 1][row + 1]) - h10)) / 256;
         end
      end
      if (h > 32767) begin
         h = 32767;
      end
      if (h < -32768) begin
         h = -32768;
      end
      s.height        = hts_pkg::height_type'(h);
      s.spot.cell_col = hts_pkg::CELL_W'(col);
      s.spot.cell_row = hts_pkg::CELL_W'(row);
      return s;
   endfunction

   function automatic int rand_height();
      case ($urandom_range(0, 7))
         0: begin
            return 32767;
         end
         1: begin
            return -32768;
         end
         default: begin
            return int'($urandom_range(0, 65535)) - 32768;
         end
      endcase
   endfunction

   task automatic push_item(input logic act, input int c, input int r, input int hv,
                            input int xq, input int zq,
                            input bit known, input sample_type known_val);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {18'(zq), 18'(xq), 16'(hv), 6'(r), 6'(c)};
      @(posedge clock iff req_tready);
      sent_items++;
      if (act == hts_pkg::ACTION_WRITE) begin
         grid_h[c][r]   = hts_pkg::height_type'(hv);
         grid_set[c][r] = 1'b1;
      end else if (known) begin
         pending_samples.push_back(known_val);
      end else begin
         pending_samples.push_back(interpolate_height(xq, zq));
      end
   endtask

   // load any unwritten corner of the cell before querying it
   task automatic send_query(input int xq, input int zq,
                             input bit known, input sample_type known_val);
      int col, row, fx, fz;
      locate(xq, zq, col, row, fx, fz);
      for (int dc = 0; dc < 2; dc++) begin
         for (int dr = 0; dr < 2; dr++) begin
            if (col + dc < across && row + dr < deep && !grid_set[col + dc][row + dr]) begin
               push_item(hts_pkg::ACTION_WRITE, col + dc, row + dr, rand_height(), 0, 0,
                         1'b0, '0);
            end
         end
      end
      push_item(hts_pkg::ACTION_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom, xq, zq, known, known_val);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_points(input int a_raw, input int d_raw);
      csr_we    <= 1'b1;
      csr_addr  <= hts_pkg::CSR_POINTS_ACROSS;
      csr_wdata <= hts_pkg::POINTS_W'(a_raw);
      @(posedge clock);
      csr_addr  <= hts_pkg::CSR_POINTS_DEEP;
      csr_wdata <= hts_pkg::POINTS_W'(d_raw);
      @(posedge clock);
      csr_we <= 1'b0;
      across = a_raw < 2 ? 2 : (a_raw > GRID_X ? GRID_X : a_raw);
      deep   = d_raw < 2 ? 2 : (d_raw > GRID_Z ? GRID_Z : d_raw);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("result with no query outstanding: rsp_tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            due                = pending_samples.pop_front();
            seen.height        = rsp_tdata[15:0];
            seen.spot.cell_col = rsp_tdata[21:16];
            seen.spot.cell_row = rsp_tdata[27:22];
            seen.spot.upper    = rsp_tdata[28];
            if (seen.height !== due.height) begin
               $error("height: expected %0d, got %0d", due.height, seen.height);
               fail_count++;
            end
            if (seen.spot.cell_col !== due.spot.cell_col) begin
               $error("cell_col: expected %0d, got %0d", due.spot.cell_col,
                      seen.spot.cell_col);
               fail_count++;
            end
            if (seen.spot.cell_row !== due.spot.cell_row) begin
               $error("cell_row: expected %0d, got %0d", due.spot.cell_row,
                      seen.spot.cell_row);
               fail_count++;
            end
            if (seen.spot.upper !== due.spot.upper) begin
               $error("upper_triangle: expected %0d, got %0d", due.spot.upper,
                      seen.spot.upper);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      sample_type ts;
      int a_raw, d_raw, xq, zq, f, lc, lr, c, r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].act == hts_pkg::ACTION_WRITE) begin
            push_item(hts_pkg::ACTION_WRITE, plan[i].col, plan[i].row, plan[i].hgt,
                      $urandom, $urandom, 1'b0, '0);
         end else begin
            ts.height        = hts_pkg::height_type'(plan[i].e_h);
            ts.spot.cell_col = hts_pkg::CELL_W'(plan[i].e_col);
            ts.spot.cell_row = hts_pkg::CELL_W'(plan[i].e_row);
            ts.spot.upper    = plan[i].e_up;
            send_query(plan[i].x, plan[i].z, plan[i].known, ts);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         a_raw = phase_across[p];
         d_raw = phase_deep[p];
         if (p == 5) begin
            a_raw = $urandom_range(0, 127);
            d_raw = $urandom_range(0, 127);
         end
         set_points(a_raw, d_raw);
         gaps_on  = (p != PHASES - 1) && $urandom_range(0, 3) != 0;
         stall_on = (p != PHASES - 1) && $urandom_range(0, 3) != 0;
         lc = across - 1;
         lr = deep - 1;
         while (sent_items < ITEMS * (p + 1) / PHASES) begin
            if ($urandom_range(0, 99) < 25) begin
               if ($urandom_range(0, 1) == 1) begin
                  c = $urandom_range(0, lc);
                  r = $urandom_range(0, lr);
               end else begin
                  c = $urandom_range(0, GRID_X - 1);
                  r = $urandom_range(0, GRID_Z - 1);
               end
               push_item(hts_pkg::ACTION_WRITE, c, r, rand_height(), $urandom, $urandom,
                         1'b0, '0);
            end else begin
               case ($urandom_range(0, 9))
                  0: begin
                     xq = int'($urandom_range(0, 262143)) - 131072;
                     zq = int'($urandom_range(0, 262143)) - 131072;
                  end
                  1: begin
                     xq = int'($urandom_range(0, lc)) * 256;
                     zq = -int'($urandom_range(0, lr)) * 256;
                  end
                  2: begin
                     f  = $urandom_range(0, 255);
                     xq = int'($urandom_range(0, lc)) * 256 + f;
                     zq = -(int'($urandom_range(0, lr)) * 256 + f);
                  end
                  default: begin
                     xq = int'($urandom_range(0, lc * 256 + 64)) - 32;
                     zq = 32 - int'($urandom_range(0, lr * 256 + 64));
                  end
               endcase
               send_query(xq, zq, 1'b0, '0);
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/hts_pkg.sv
hdl/hts_bank.sv
hdl/heightfield_triangle_sample.sv
bench/tb_heightfield_triangle_sample.sv
